/* sv/ple_pkg.sv */
// Package: request/response beat types, action and status codes for the list engine.
package ple_pkg;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;
	localparam logic [1:0] ACT_SEARCH = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [5:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic               found;
		logic [5:0]         count;
	} rsp_t;

	// per-cycle operation broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
		logic rd;
		logic srch;
	} ctl_t;

endpackage

/* sv/positional_list_engine.sv */
// Top level: positional list engine built from a chain of shifting cells.
// Ordered list of signed 32-bit entries, up to CAPACITY of them. A request
// beat (insert at position, delete at position, read at position, search for
// value) is taken when the engine is idle and its response register is free
// or being emptied. The response is registered after the request is
// accepted: in the EXEC state every cell shifts or compares in parallel,
// whatever the list length, and in the RED state the per-cell results are
// ORed into the response register. One request is in flight at a time, so
// no new request is taken until the last response is registered. Position 1 is the
// head; bad positions report status 1 and a full list on insert reports
// status 2, with the list left unchanged. Count is reported in 6 bits.
module positional_list_engine #(
	parameter int CAPACITY = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ple_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ple_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 6) ? CW : 6) + 1;
	localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RED} state_t;

	state_t             state_q;
	ple_pkg::req_t      cmd_s1;
	logic [CW-1:0]      count_q;
	logic [1:0]         status_s2;
	logic               rsp_valid_q;
	ple_pkg::rsp_t      rsp_q;

	logic               accept;
	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      pos0;
	logic [XW-1:0]      count_x;
	logic [1:0]         status_c;
	ple_pkg::ctl_t      ctl;

	logic signed [31:0] data   [CAPACITY];
	logic signed [31:0] rd_s2  [CAPACITY];
	logic               fnd_s2 [CAPACITY];
	logic signed [31:0] rd_or;
	logic               fnd_or;

	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;

	assign pos_x   = XW'(cmd_s1.position);
	assign pos0    = pos_x - XW'(1);
	assign count_x = XW'(count_q);

	always_comb begin
		status_c = ple_pkg::ST_OK;
		case (cmd_s1.action)
			ple_pkg::ACT_INSERT: begin
				if (pos_x == '0 || pos_x > count_x + XW'(1)) begin
					status_c = ple_pkg::ST_BADPOS;
				end else if (count_x >= CAP_X) begin
					status_c = ple_pkg::ST_FULL;
				end
			end
			ple_pkg::ACT_DELETE, ple_pkg::ACT_READ: begin
				if (pos_x == '0 || pos_x > count_x) begin
					status_c = ple_pkg::ST_BADPOS;
				end
			end
			default: status_c = ple_pkg::ST_OK;
		endcase
	end

	always_comb begin
		ctl.ins  = (state_q == S_EXEC) && (cmd_s1.action == ple_pkg::ACT_INSERT)
			&& (status_c == ple_pkg::ST_OK);
		ctl.del  = (state_q == S_EXEC) && (cmd_s1.action == ple_pkg::ACT_DELETE)
			&& (status_c == ple_pkg::ST_OK);
		ctl.rd   = (state_q == S_EXEC) && (cmd_s1.action == ple_pkg::ACT_READ)
			&& (status_c == ple_pkg::ST_OK);
		ctl.srch = (state_q == S_EXEC) && (cmd_s1.action == ple_pkg::ACT_SEARCH);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;
		if (i == 0) begin : g_head
			assign left_w = cmd_s1.value;
		end else begin : g_left
			assign left_w = data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = 32'sd0;
		end else begin : g_right
			assign right_w = data[i+1];
		end
		ple_cell #(.IW(XW)) u_cell (
			.clk    (clk),
			.idx    (XW'(i)),
			.ctl    (ctl),
			.pos0   (pos0),
			.count  (count_x),
			.value  (cmd_s1.value),
			.left   (left_w),
			.right  (right_w),
			.data   (data[i]),
			.rd_s2  (rd_s2[i]),
			.fnd_s2 (fnd_s2[i])
		);
	end

	// read hits are one-hot, so an OR picks the entry
	always_comb begin
		rd_or  = 32'sd0;
		fnd_or = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or  = rd_or | rd_s2[i];
			fnd_or = fnd_or | fnd_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= req;
		end
		if (state_q == S_EXEC) begin
			status_s2 <= status_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ctl.ins) begin
						count_q <= count_q + CW'(1);
					end else if (ctl.del) begin
						count_q <= count_q - CW'(1);
					end
					state_q <= S_RED;
				end
				S_RED: begin
					rsp_q.status     <= status_s2;
					rsp_q.read_value <= rd_or;
					rsp_q.found      <= fnd_or;
					rsp_q.count      <= count_x[5:0];
					rsp_valid_q      <= 1'b1;
					state_q          <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 rsp_valid)
		else $error("response not produced three cycles after request");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= CAP_X)
		else $error("entry count beyond capacity");

	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found)
			|-> (rsp.status == ple_pkg::ST_OK && rsp.read_value == 32'sd0))
		else $error("search response carries status or read data");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RED) |-> (!rsp_valid || !rsp_stall))
		else $error("response register overwritten before taken");
`endif

endmodule

/* sv/ple_cell.sv */
// One list cell: holds an entry, shifts with its neighbors, answers read and search.
module ple_cell #(
	parameter int IW = 7
) (
	input  logic                clk,
	input  logic [IW-1:0]       idx,
	input  ple_pkg::ctl_t       ctl,
	input  logic [IW-1:0]       pos0,
	input  logic [IW-1:0]       count,
	input  logic signed [31:0]  value,
	input  logic signed [31:0]  left,
	input  logic signed [31:0]  right,
	output logic signed [31:0]  data,
	output logic signed [31:0]  rd_s2,
	output logic                fnd_s2
);

	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx == pos0) begin
				data_q <= value;
			end else if (idx > pos0) begin
				data_q <= left;
			end
		end else if (ctl.del) begin
			if (idx >= pos0) begin
				data_q <= right;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_s2  <= (ctl.rd && idx == pos0) ? data_q : 32'sd0;
		fnd_s2 <= ctl.srch && (idx < count) && (data_q == value);
	end

	assign data = data_q;

endmodule
